// ----- sv/trht_pkg.sv -----
// Package for the touch region hit table: sizes, field offsets, mode codes,
// the region record and the controller/datapath command and status structs.
// No dependencies.
package trht_pkg;

    localparam int SLOTS      = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W     = 4;

    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);

    // Input tdata layout, lowest bit first
    localparam int OFF_SLOT  = 0;
    localparam int OFF_RX    = 4;
    localparam int OFF_RY    = 20;
    localparam int OFF_RW    = 36;
    localparam int OFF_RH    = 52;
    localparam int OFF_SD    = 68;
    localparam int OFF_TX    = 69;
    localparam int OFF_TY    = 85;
    localparam int IN_DATA_W = 104;
    localparam int IN_USER_W = 3;

    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_DEL = 3'd1,
        MODE_EN  = 3'd2,
        MODE_DIS = 3'd3,
        MODE_QRY = 3'd4,
        MODE_HIT = 3'd5
    } t_mode;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } t_rect;

    typedef struct packed {
        logic load_item;
        logic edit;
        logic scan_clr;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  scan_done;
        logic  out_free;
    } t_sts;

endpackage

// ----- sv/trht_dp.sv -----
// Datapath of the touch region hit table: item register, slot marks,
// region memory, scan counter, hit compare and output register.
// Depends on trht_pkg.
module trht_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  trht_pkg::t_cmd                  i_cmd,
    output trht_pkg::t_sts                  o_sts,
    input  logic [trht_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [trht_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [trht_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import trht_pkg::*;

    function automatic logic f_inside(input logic [COORD_BITS-1:0] p,
                                      input logic [COORD_BITS-1:0] lo,
                                      input logic [COORD_BITS-1:0] len);
        logic [COORD_BITS:0] hi;
        hi = {1'b0, lo} + {1'b0, len};
        return (p > lo) && ({1'b0, p} < hi);
    endfunction

    t_mode                 r_mode;
    logic [SLOT_W-1:0]     r_slot;
    t_rect                 r_rect;
    logic                  r_sd;
    logic [COORD_BITS-1:0] r_tx;
    logic [COORD_BITS-1:0] r_ty;

    logic [SLOTS-1:0]      r_used;
    logic [SLOTS-1:0]      r_dis;
    t_rect                 r_mem [SLOTS];
    t_rect                 r_rd;

    logic [IDX_W-1:0]      r_cnt;
    logic                  r_iss_done;
    logic                  r_pv;
    logic [IDX_W-1:0]      r_pidx;

    logic                  r_ok;
    logic [SLOT_W-1:0]     r_found;
    logic                  r_en;

    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_add_mode;
    logic                  w_add_free;
    logic                  w_add_wr;
    logic                  w_hit;
    logic                  w_hit_upd;
    logic [7:0]            w_slot8;
    logic                  w_slot_ok;
    logic [IDX_W-1:0]      w_sidx;
    logic [7:0]            w_cnt8;
    logic [7:0]            w_pidx8;

    assign w_slot8    = 8'(r_slot);
    assign w_slot_ok  = w_slot8 < 8'(SLOTS);
    assign w_sidx     = w_slot8[IDX_W-1:0];
    assign w_cnt8     = 8'(r_cnt);
    assign w_pidx8    = 8'(r_pidx);

    assign w_add_mode = (r_mode == MODE_ADD);
    assign w_add_free = !r_used[r_cnt];
    assign w_add_wr   = i_cmd.scan && w_add_mode && w_add_free;
    assign w_hit      = r_pv && r_used[r_pidx] && !r_dis[r_pidx]
                        && f_inside(r_tx, r_rd.left, r_rd.width)
                        && f_inside(r_ty, r_rd.top, r_rd.height);
    assign w_hit_upd  = i_cmd.scan && !w_add_mode && w_hit;

    assign o_sts.mode      = r_mode;
    assign o_sts.scan_done = w_add_mode ? (w_add_free || (r_cnt == SLOT_LAST))
                                        : (w_hit || (r_pv && (r_pidx == SLOT_LAST)));
    assign o_sts.out_free  = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode      <= t_mode'(i_s_tuser);
            r_slot      <= i_s_tdata[OFF_SLOT +: SLOT_W];
            r_rect.left   <= i_s_tdata[OFF_RX +: COORD_BITS];
            r_rect.top    <= i_s_tdata[OFF_RY +: COORD_BITS];
            r_rect.width  <= i_s_tdata[OFF_RW +: COORD_BITS];
            r_rect.height <= i_s_tdata[OFF_RH +: COORD_BITS];
            r_sd        <= i_s_tdata[OFF_SD];
            r_tx        <= i_s_tdata[OFF_TX +: COORD_BITS];
            r_ty        <= i_s_tdata[OFF_TY +: COORD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_dis  <= '0;
        end else begin
            if (i_cmd.edit && w_slot_ok && r_used[w_sidx]) begin
                case (r_mode)
                    MODE_DEL: begin
                        r_used[w_sidx] <= 1'b0;
                        r_dis[w_sidx]  <= 1'b0;
                    end
                    MODE_EN:  r_dis[w_sidx] <= 1'b0;
                    MODE_DIS: r_dis[w_sidx] <= 1'b1;
                    default: ;
                endcase
            end
            if (w_add_wr) begin
                r_used[r_cnt] <= 1'b1;
                r_dis[r_cnt]  <= r_sd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add_wr) begin
            r_mem[r_cnt] <= r_rect;
        end
        r_rd <= r_mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_iss_done <= 1'b0;
            r_pv       <= 1'b0;
            r_pidx     <= '0;
        end else if (i_cmd.scan_clr) begin
            r_cnt      <= '0;
            r_iss_done <= 1'b0;
            r_pv       <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_add_mode) begin
                if (!w_add_free && (r_cnt != SLOT_LAST)) begin
                    r_cnt <= IDX_W'(r_cnt + 1'b1);
                end
            end else if (!r_iss_done) begin
                r_pv   <= 1'b1;
                r_pidx <= r_cnt;
                if (r_cnt == SLOT_LAST) begin
                    r_iss_done <= 1'b1;
                end else begin
                    r_cnt <= IDX_W'(r_cnt + 1'b1);
                end
            end else begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ok    <= 1'b0;
            r_found <= '0;
            r_en    <= 1'b0;
        end else begin
            if (i_cmd.edit && (r_mode == MODE_QRY) && w_slot_ok) begin
                r_en <= !r_dis[w_sidx];
            end
            if (w_add_wr) begin
                r_ok    <= 1'b1;
                r_found <= w_cnt8[SLOT_W-1:0];
            end
            if (w_hit_upd) begin
                r_ok    <= 1'b1;
                r_found <= w_pidx8[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {2'b00, r_en, r_found, r_ok};
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_m_tready))
        else $error("result loaded over an untaken transfer");

    a_add_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_wr |=> r_used[$past(r_cnt)])
        else $error("added slot not marked used");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ----- sv/trht_ctrl.sv -----
// Controller of the touch region hit table: sequences accept, decode,
// slot scan and result hand-off. Depends on trht_pkg.
module trht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output trht_pkg::t_cmd o_cmd,
    input  trht_pkg::t_sts i_sts
);
    import trht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.mode)
                    MODE_ADD, MODE_HIT: begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                    MODE_DEL, MODE_EN, MODE_DIS, MODE_QRY: begin
                        o_cmd.edit = 1'b1;
                        n_state    = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DECODE))
        else $error("accepted transfer not decoded");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE))
        else $error("no return to idle after result");

endmodule

// ----- sv/touch_region_hit_table_top.sv -----
// Top level of the touch region hit table: controller plus datapath.
// Depends on trht_pkg, trht_ctrl and trht_dp.
//
// Usage:
//   Slave channel s_*: one operation per transfer. tuser carries the mode
//   (add, delete, enable, disable, query, hit test); tdata carries slot,
//   rectangle, start-disabled flag and touch point.
//   Master channel m_*: exactly one result transfer per operation
//   (ok, found slot, enabled flag).
//   One operation at a time. Delete, enable, disable, query and unknown
//   modes finish without a scan. Add scans the slots one per cycle up to
//   the first free one; hit test scans one slot per cycle through the
//   region memory's single read port up to the first hit.
//   s_tready rises again the cycle after the result is loaded.
//   Reset clears the used and disabled marks (table empty) and the output
//   valid flag; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   operation is accepted meanwhile and waits at the hand-off until taken.
module touch_region_hit_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot[3:0], rect_x[19:4], rect_y[35:20], rect_w[51:36], rect_h[67:52],
    // start_disabled[68], touch_x[84:69], touch_y[100:85], zero[103:101]
    input  logic [trht_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [trht_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok[0], found_slot[4:1], is_enabled[5], zero[7:6]
    output logic [trht_pkg::OUT_DATA_W-1:0] m_tdata
);
    import trht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    trht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    trht_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule
